// ----- sv/u8d_pkg.sv -----
`default_nettype none

package u8d_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0]  LeadTwoLo   = 8'hC2;
  localparam logic [7:0]  LeadTwoHi   = 8'hDF;
  localparam logic [7:0]  LeadThreeLo = 8'hE0;
  localparam logic [7:0]  LeadThreeHi = 8'hEF;
  localparam logic [7:0]  LeadFourLo  = 8'hF0;
  localparam logic [7:0]  LeadFourHi  = 8'hF4;
  localparam logic [5:0]  ContMask    = 6'h3F;
  localparam logic [20:0] MinThree    = 21'h000800;
  localparam logic [20:0] MinFour     = 21'h010000;
  localparam logic [20:0] SurrLo      = 21'h00D800;
  localparam logic [20:0] SurrHi      = 21'h00DFFF;
  localparam logic [20:0] MaxScalar   = 21'h10FFFF;

  localparam logic KindCode  = 1'b0;
  localparam logic KindError = 1'b1;

  // work for the back end: flushed held bytes first, then an optional tail result
  typedef struct packed {
    logic [1:0]      flush_cnt;
    logic [2:0][7:0] flush_bytes;
    logic            tail_vld;
    logic            tail_kind;
    logic [20:0]     tail_cp;
    logic [2:0]      tail_len;
    logic [7:0]      tail_bad;
    logic            text_valid;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
// UTF-8 stream decoder and validator.
// Input stream s_axis: one text byte per transfer in tdata, tlast marks the
// last byte of a text. Output stream m_axis: one result per transfer; tuser
// is the kind (0 code point, 1 skipped invalid byte), tlast marks the last
// result caused by one input byte, and tdata carries code point, sequence
// length, the rejected byte and the text validity flag (set on the final
// result of a text when no error occurred in it).
// A byte may cause zero to four results: continuation bytes of an open
// sequence give nothing until the sequence ends, a failed sequence gives one
// error per held byte.
// Results of an input byte pass through the job queue and the output register.
// One byte is taken per cycle while the job queue has room; the output side
// drains one result per cycle while the receiver is ready, so only error
// bursts with several results per byte slow the input. The job queue
// decouples the two sides so a stalled receiver backs up into the queue and
// then into s_axis_tready. Synchronous reset empties the queue and the
// output register and clears the open sequence and the sticky error flag.
`default_nettype none

module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,  // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [20:0] codepoint, [23:21] seq_length, [31:24] bad_byte, [32] text_valid, [39:33] zero
  output logic [39:0]      m_axis_tdata,
  output logic [0:0]       m_axis_tuser,  // [0] kind
  output logic             m_axis_tlast   // last_of_run
);

  logic        q_full;
  logic        push;
  job_t        push_job;
  logic        q_not_empty;
  job_t        head_job;
  logic        pop;

  logic        kind;
  logic [20:0] codepoint;
  logic [2:0]  seq_length;
  logic [7:0]  bad_byte;
  logic        text_valid;

  u8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .data_byte   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .q_full      (q_full),
    .job_valid   (push),
    .job         (push_job)
  );

  u8d_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  u8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_present (q_not_empty),
    .job         (head_job),
    .job_done    (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .kind        (kind),
    .codepoint   (codepoint),
    .seq_length  (seq_length),
    .bad_byte    (bad_byte),
    .text_valid  (text_valid),
    .last_of_run (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, text_valid, bad_byte, seq_length, codepoint};
  assign m_axis_tuser = kind;

endmodule

`default_nettype wire

// ----- sv/u8d_front.sv -----
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_text,
  input  wire logic       q_full,
  output logic            job_valid,
  output job_t            job
);

  logic [1:0]      needed_count, needed_count_next;
  logic [1:0]      held_count, held_count_next;
  logic [2:0][7:0] held_bytes;
  logic [20:0]     partial_value, partial_value_next;
  logic            error_seen, error_seen_next;

  logic            accept;
  logic            in_seq;
  logic            is_cont;
  logic [20:0]     shifted;
  logic [2:0]      total;
  logic            bad_value;
  logic            store_cont;
  logic            store_lead;
  logic [2:0]      n_results;
  logic            any_err;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign in_seq   = (needed_count != 2'd0);
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign shifted  = {partial_value[14:0], data_byte[5:0] & ContMask};
  assign total    = {1'b0, held_count} + 3'd1;

  assign bad_value = ((total == 3'd3) && (shifted < MinThree)) ||
                     ((total == 3'd4) && (shifted < MinFour)) ||
                     ((shifted >= SurrLo) && (shifted <= SurrHi)) ||
                     (shifted > MaxScalar);

  always_comb begin
    needed_count_next  = needed_count;
    held_count_next    = held_count;
    partial_value_next = partial_value;
    store_cont         = 1'b0;
    store_lead         = 1'b0;
    job                = '0;
    job.flush_bytes    = held_bytes;
    job.tail_len       = 3'd1;

    if (in_seq && is_cont) begin
      if (needed_count == 2'd1) begin
        needed_count_next  = 2'd0;
        held_count_next    = 2'd0;
        partial_value_next = '0;
        job.tail_vld       = 1'b1;
        if (bad_value) begin
          job.flush_cnt = held_count;
          job.tail_kind = KindError;
          job.tail_bad  = data_byte;
        end else begin
          job.tail_kind = KindCode;
          job.tail_cp   = shifted;
          job.tail_len  = total;
        end
      end else if (end_of_text) begin
        job.flush_cnt = held_count;
        job.tail_vld  = 1'b1;
        job.tail_kind = KindError;
        job.tail_bad  = data_byte;
      end else begin
        store_cont         = 1'b1;
        held_count_next    = held_count + 2'd1;
        needed_count_next  = needed_count - 2'd1;
        partial_value_next = shifted;
      end
    end else begin
      // a byte that breaks a sequence flushes it and is then taken as fresh
      job.flush_cnt      = in_seq ? held_count : 2'd0;
      needed_count_next  = 2'd0;
      held_count_next    = 2'd0;
      partial_value_next = '0;
      if (!data_byte[7]) begin
        job.tail_vld  = 1'b1;
        job.tail_kind = KindCode;
        job.tail_cp   = {13'd0, data_byte};
      end else if ((data_byte >= LeadTwoLo && data_byte <= LeadFourHi) && !end_of_text) begin
        store_lead      = 1'b1;
        held_count_next = 2'd1;
        if (data_byte <= LeadTwoHi) begin
          needed_count_next  = 2'd1;
          partial_value_next = {16'd0, data_byte[4:0]};
        end else if (data_byte >= LeadThreeLo && data_byte <= LeadThreeHi) begin
          needed_count_next  = 2'd2;
          partial_value_next = {17'd0, data_byte[3:0]};
        end else begin
          needed_count_next  = 2'd3;
          partial_value_next = {18'd0, data_byte[2:0]};
        end
      end else begin
        // invalid lead, or a valid lead cut short by end of text
        job.tail_vld  = 1'b1;
        job.tail_kind = KindError;
        job.tail_bad  = data_byte;
      end
    end

    n_results = {1'b0, job.flush_cnt} + {2'd0, job.tail_vld};
    any_err   = (job.flush_cnt != 2'd0) || (job.tail_vld && job.tail_kind == KindError);
    job.text_valid = end_of_text && !(error_seen || any_err);
    job_valid = accept && (n_results != 3'd0);

    error_seen_next = error_seen || any_err;
    if (end_of_text) begin
      error_seen_next    = 1'b0;
      needed_count_next  = 2'd0;
      held_count_next    = 2'd0;
      partial_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needed_count  <= '0;
      held_count    <= '0;
      partial_value <= '0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      needed_count  <= needed_count_next;
      held_count    <= held_count_next;
      partial_value <= partial_value_next;
      error_seen    <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_lead) begin
      held_bytes[0] <= data_byte;
    end else if (accept && store_cont && held_count != 2'd3) begin
      held_bytes[held_count] <= data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/u8d_queue.sv -----
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head_job
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          entries [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(Depth));
  assign not_empty = (count != '0);
  assign head_job  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- sv/u8d_back.sv -----
`default_nettype none

module u8d_back
  import u8d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  job_present,
  input  wire job_t  job,
  output logic       job_done,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       kind,
  output logic [20:0] codepoint,
  output logic [2:0] seq_length,
  output logic [7:0] bad_byte,
  output logic       text_valid,
  output logic       last_of_run
);

  logic [1:0] idx, idx_next;
  logic [2:0] n_results;
  logic       is_flush;
  logic       is_last;
  logic       advance;
  logic       emit;

  assign n_results = {1'b0, job.flush_cnt} + {2'd0, job.tail_vld};
  assign is_flush  = (idx < job.flush_cnt);
  assign is_last   = (({1'b0, idx} + 3'd1) == n_results);
  assign advance   = !out_valid || out_ready;
  assign emit      = job_present && advance;
  assign job_done  = emit && is_last;
  assign idx_next  = job_done ? 2'd0 : idx + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx <= idx_next;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_of_run <= is_last;
      text_valid  <= is_last && job.text_valid;
      if (is_flush) begin
        kind       <= KindError;
        codepoint  <= '0;
        seq_length <= 3'd1;
        bad_byte   <= job.flush_bytes[idx];
      end else begin
        kind       <= job.tail_kind;
        codepoint  <= job.tail_cp;
        seq_length <= job.tail_len;
        bad_byte   <= job.tail_bad;
      end
    end
  end

endmodule

`default_nettype wire
